// ----- hw/rtl/mfe_pkg.sv -----
// Shared types and constants of the metaball field evaluator.
package mfe_pkg;
    localparam int MaxBalls  = 16;
    localparam int SlotBits  = $clog2(MaxBalls);
    localparam int IndexBits = 8;
    localparam int CoordBits = 24;
    localparam int RadBits   = 16;
    localparam int ResBits   = 16;
    localparam int CountBits = $clog2(MaxBalls + 1);
    localparam int EntryBits = 3 * CoordBits + RadBits;
    localparam int DiffBits  = IndexBits + ResBits + 2;
    localparam int SqBits    = 2 * DiffBits;
    localparam int D2Bits    = SqBits + 2;
    localparam int DistBits  = (D2Bits + 1) / 2;
    localparam int NumBits   = RadBits + 16;
    localparam int AccBits   = 32 + CountBits + 1;

    localparam logic [1:0] CfgResolution = 2'd0;
    localparam logic [1:0] CfgBallCount  = 2'd1;

    typedef struct packed {
        logic                        mode;
        logic [3:0]                  ball_slot;
        logic signed [CoordBits-1:0] center_x;
        logic signed [CoordBits-1:0] center_y;
        logic signed [CoordBits-1:0] center_z;
        logic [RadBits-1:0]          ball_radius;
        logic signed [IndexBits-1:0] index_x;
        logic signed [IndexBits-1:0] index_y;
        logic signed [IndexBits-1:0] index_z;
    } t_in;

    typedef struct packed {
        logic [31:0] isovalue;
        logic        saturated;
    } t_out;

    typedef struct packed {
        logic load_point;   // latch grid point (indices times resolution)
        logic clear_acc;
        logic diff;         // entry data to differences
        logic sq_start;     // begin axis-square sequence
        logic sq_step;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic accum;
    } t_cmd;

    typedef struct packed {
        logic sq_done;
        logic sqrt_done;
        logic div_done;
    } t_sts;
endpackage

// ----- hw/rtl/mfe_ram.sv -----
// Generic single-port-write RAM with registered read.
module mfe_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/mfe_datapath.sv -----
// Datapath: grid point, squared distance, square root, divider and accumulator.
module mfe_datapath (
    input  logic                            i_clk,
    input  mfe_pkg::t_cmd                   i_cmd,
    output mfe_pkg::t_sts                   o_sts,
    input  logic [mfe_pkg::ResBits-1:0]     i_resolution,
    input  mfe_pkg::t_in                    i_item,
    input  logic [mfe_pkg::EntryBits-1:0]   i_entry,
    output logic [31:0]                     o_isovalue,
    output logic                            o_saturated
);
    localparam int DB = mfe_pkg::DiffBits;
    localparam int QB = mfe_pkg::SqBits;
    localparam int D2 = mfe_pkg::D2Bits;
    localparam int SB = mfe_pkg::DistBits;
    localparam int NB = mfe_pkg::NumBits;
    localparam int AB = mfe_pkg::AccBits;
    localparam int CB = mfe_pkg::CoordBits;
    localparam int RB = mfe_pkg::RadBits;
    localparam int IB = mfe_pkg::IndexBits;
    localparam int PB = IB + mfe_pkg::ResBits + 1;

    logic signed [PB-1:0] r_px, r_py, r_pz;
    logic signed [DB-1:0] r_dx, r_dy, r_dz;
    logic [RB-1:0]        r_rad;
    logic [1:0]           r_axis;
    logic [D2-1:0]        r_d2;
    logic [D2-1:0]        r_rem;
    logic [SB-1:0]        r_root;
    logic [5:0]           r_cnt;
    logic [NB-1:0]        r_quo;
    logic [SB:0]          r_drem;
    logic [AB-1:0]        r_acc;
    logic                 r_sat;
    logic                 r_sq_done, r_sqrt_done, r_div_done;

    logic signed [DB-1:0] sel_diff;
    logic [DB-1:0]        abs_diff;
    logic [QB-1:0]        prod;
    logic [D2+1:0]        trial;
    logic [D2+1:0]        rem_sh;
    logic [SB+1:0]        dtrial;

    always_comb begin
        case (r_axis)
            2'd0:    sel_diff = r_dx;
            2'd1:    sel_diff = r_dy;
            default: sel_diff = r_dz;
        endcase
        abs_diff = sel_diff[DB-1] ? DB'(-sel_diff) : DB'(sel_diff);
        prod = QB'(abs_diff) * QB'(abs_diff);
        // Restoring square root, one result bit a step.
        rem_sh = {r_rem, r_d2[D2-1 -: 2]};
        trial  = (D2+2)'({r_root, 2'b01});
        // Restoring division, one quotient bit a step.
        dtrial = {r_drem, r_quo[NB-1]} - (SB+2)'(r_root);
    end

    always_ff @(posedge i_clk) begin
        r_sq_done <= 1'b0;
        r_sqrt_done <= 1'b0;
        r_div_done <= 1'b0;
        if (i_cmd.load_point) begin
            r_px <= PB'(i_item.index_x) * $signed({1'b0, i_resolution});
            r_py <= PB'(i_item.index_y) * $signed({1'b0, i_resolution});
            r_pz <= PB'(i_item.index_z) * $signed({1'b0, i_resolution});
        end
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end
        if (i_cmd.diff) begin
            r_dx <= DB'(r_px) - DB'($signed(i_entry[RB+3*CB-1 -: CB]));
            r_dy <= DB'(r_py) - DB'($signed(i_entry[RB+2*CB-1 -: CB]));
            r_dz <= DB'(r_pz) - DB'($signed(i_entry[RB+CB-1 -: CB]));
            r_rad <= i_entry[RB-1:0];
        end
        if (i_cmd.sq_start) begin
            r_axis <= 2'd0;
            r_d2 <= '0;
        end else if (i_cmd.sq_step) begin
            r_d2 <= r_d2 + D2'(prod);
            r_axis <= r_axis + 2'd1;
            r_sq_done <= (r_axis == 2'd2);
        end
        if (i_cmd.sqrt_start) begin
            r_rem <= '0;
            r_root <= '0;
            r_cnt <= 6'(SB - 1);
        end else if (i_cmd.sqrt_step) begin
            r_d2 <= {r_d2[D2-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem <= D2'(rem_sh - trial);
                r_root <= {r_root[SB-2:0], 1'b1};
            end else begin
                r_rem <= D2'(rem_sh);
                r_root <= {r_root[SB-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            r_sqrt_done <= (r_cnt == 6'd0);
        end
        if (i_cmd.div_start) begin
            r_quo <= {r_rad, 16'd0};
            r_drem <= '0;
            r_cnt <= 6'(NB - 1);
        end else if (i_cmd.div_step) begin
            if (!dtrial[SB+1]) begin
                r_drem <= dtrial[SB:0];
                r_quo <= {r_quo[NB-2:0], 1'b1};
            end else begin
                r_drem <= {r_drem[SB-1:0], r_quo[NB-1]};
                r_quo <= {r_quo[NB-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            r_div_done <= (r_cnt == 6'd0);
        end
        if (i_cmd.accum) begin
            if (r_root == '0) begin
                r_acc <= r_acc + AB'(32'hFFFF_FFFF);
                r_sat <= 1'b1;
            end else begin
                r_acc <= r_acc + AB'(r_quo);
            end
        end
    end

    assign o_sts = '{sq_done: r_sq_done, sqrt_done: r_sqrt_done, div_done: r_div_done};
    assign o_isovalue = (r_acc > AB'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : r_acc[31:0];
    assign o_saturated = r_sat || (r_acc > AB'(32'hFFFF_FFFF));
endmodule

// ----- hw/rtl/mfe_ctrl.sv -----
// Controller: sequences ball loads and the per-ball evaluation steps.
module mfe_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [mfe_pkg::CountBits-1:0]   i_ball_count,
    output logic [mfe_pkg::SlotBits-1:0]    o_raddr,
    output mfe_pkg::t_cmd                   o_cmd,
    input  mfe_pkg::t_sts                   i_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_stall
);
    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_WAIT, S_DIFF, S_SQ, S_SQRT, S_DIV, S_ACC, S_OUT
    } t_state;

    localparam int CB = mfe_pkg::CountBits;
    localparam int SL = mfe_pkg::SlotBits;

    t_state        r_state, n_state;
    logic [CB-1:0] r_idx, n_idx, r_num, n_num;
    logic          r_out_valid, n_out_valid;
    logic          accept;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign o_raddr = r_idx[SL-1:0];

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_num = r_num;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_mode) begin
                    o_cmd.load_point = 1'b1;
                    o_cmd.clear_acc = 1'b1;
                    n_idx = '0;
                    n_num = (i_ball_count > CB'(mfe_pkg::MaxBalls))
                          ? CB'(mfe_pkg::MaxBalls) : i_ball_count;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_idx == r_num) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_DIFF;
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                o_cmd.sq_start = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_done) begin
                    o_cmd.sq_step = 1'b0;
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_done) begin
                    o_cmd.sqrt_step = 1'b0;
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.div_step = 1'b0;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_idx = r_idx + CB'(1);
                n_state = S_READ;
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            r_num <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_num <= n_num;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- hw/rtl/metaball_field_evaluator.sv -----
// Top level of the metaball field evaluator: table, controller and datapath.
//
//  Channel  | Signals                          | Beat
//  ---------+----------------------------------+--------------------------------
//  input    | i_in_valid, o_in_stall, i_in     | one load or evaluate item
//  output   | o_out_valid, i_out_stall, o_out  | one isovalue per evaluate item
//  config   | i_cfg_we, i_cfg_index, i_cfg_data| one register write
//
// A load beat writes its table entry in the cycle it is accepted and the block
// is free again at once. An evaluate beat has its result offered once every
// active ball has passed through the table read and differences, the squared
// distance, the bit-serial square root, the bit-serial divider and the
// accumulation, in that order.
// Reset is synchronous and active low; it clears control state and configuration registers.
// The input is stalled while an evaluation runs or its result waits to be taken.
module metaball_field_evaluator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mfe_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mfe_pkg::t_out                 o_out,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    logic [mfe_pkg::ResBits-1:0]   r_resolution;
    logic [mfe_pkg::CountBits-1:0] r_ball_count;
    logic [mfe_pkg::SlotBits-1:0]  raddr;
    logic [mfe_pkg::EntryBits-1:0] entry;
    mfe_pkg::t_cmd                 cmd;
    mfe_pkg::t_sts                 sts;
    logic                          load_we;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= 16'd1638;
            r_ball_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mfe_pkg::CfgResolution: r_resolution <= i_cfg_data;
                mfe_pkg::CfgBallCount:  r_ball_count <= i_cfg_data[mfe_pkg::CountBits-1:0];
                default: ;
            endcase
        end
    end

    // A load beat goes straight into the ball table.
    assign load_we = i_in_valid && !o_in_stall && !i_in.mode;

    mfe_ram #(
        .Width(mfe_pkg::EntryBits),
        .Depth(mfe_pkg::MaxBalls)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_waddr(i_in.ball_slot[mfe_pkg::SlotBits-1:0]),
        .i_wdata({i_in.center_x, i_in.center_y, i_in.center_z, i_in.ball_radius}),
        .i_raddr(raddr),
        .o_rdata(entry)
    );

    mfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_in.mode),
        .i_ball_count(r_ball_count),
        .o_raddr     (raddr),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    mfe_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_resolution(r_resolution),
        .i_item      (i_in),
        .i_entry     (entry),
        .o_isovalue  (o_out.isovalue),
        .o_saturated (o_out.saturated)
    );
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the metaball field evaluator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int RandomItems   = 1170;
    localparam int DrainCycles   = 40;
    localparam int InBits        = $bits(mfe_pkg::t_in);

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    mfe_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    mfe_pkg::t_out o_out;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [15:0]   i_cfg_data;

    metaball_field_evaluator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the block's registers and ball table, used by the predictor.
    logic [15:0]           shadow_resolution;
    logic [4:0]            shadow_count;
    logic signed [23:0]    shadow_cx [mfe_pkg::MaxBalls];
    logic signed [23:0]    shadow_cy [mfe_pkg::MaxBalls];
    logic signed [23:0]    shadow_cz [mfe_pkg::MaxBalls];
    logic [15:0]           shadow_radius [mfe_pkg::MaxBalls];

    mfe_pkg::t_out isovalue_queue[$];
    int      mismatch_count;
    int      idle_cycles;
    bit      timed_out;

    // Directed table: each row is one beat, with an optional typed-in result.
    typedef struct {
        mfe_pkg::t_in  beat;
        bit            has_known;
        mfe_pkg::t_out known;
    } t_row;

    t_row directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Integer square root, floored, by the usual bit-pair method.
    function automatic longint unsigned floor_sqrt(input longint unsigned val);
        longint unsigned root;
        longint unsigned bitpos;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > val) bitpos >>= 2;
        while (bitpos != 0) begin
            if (val >= root + bitpos) begin
                val  -= root + bitpos;
                root  = (root >> 1) + bitpos;
            end else begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned square_of(input longint signed d);
        longint unsigned mag;
        mag = d < 0 ? longint'(-d) : d;
        return mag * mag;
    endfunction

    // Sums radius over distance for the active balls at one grid point.
    function automatic mfe_pkg::t_out field_at_point(input mfe_pkg::t_in beat);
        longint signed   px;
        longint signed   py;
        longint signed   pz;
        longint unsigned d2;
        longint unsigned distance;
        longint unsigned acc;
        int              active;
        mfe_pkg::t_out   res;
        px = longint'(beat.index_x) * longint'({1'b0, shadow_resolution});
        py = longint'(beat.index_y) * longint'({1'b0, shadow_resolution});
        pz = longint'(beat.index_z) * longint'({1'b0, shadow_resolution});
        active = shadow_count > mfe_pkg::MaxBalls ? mfe_pkg::MaxBalls : shadow_count;
        acc = 0;
        res.saturated = 1'b0;
        for (int m = 0; m < active; m++) begin
            d2 = square_of(px - longint'(shadow_cx[m])) + square_of(py - longint'(shadow_cy[m]))
               + square_of(pz - longint'(shadow_cz[m]));
            distance = floor_sqrt(d2);
            if (distance == 0) begin
                acc += 64'hFFFF_FFFF;
                res.saturated = 1'b1;
            end else begin
                acc += ({48'd0, shadow_radius[m]} << 16) / distance;
            end
        end
        if (acc > 64'hFFFF_FFFF) begin
            acc = 64'hFFFF_FFFF;
            res.saturated = 1'b1;
        end
        res.isovalue = acc[31:0];
        return res;
    endfunction

    // Updates the shadow state for one accepted beat and queues any result.
    task automatic predict_beat(input mfe_pkg::t_in beat);
        if (beat.mode == 1'b0) begin
            shadow_cx[beat.ball_slot]     = beat.center_x;
            shadow_cy[beat.ball_slot]     = beat.center_y;
            shadow_cz[beat.ball_slot]     = beat.center_z;
            shadow_radius[beat.ball_slot] = beat.ball_radius;
        end else begin
            isovalue_queue = {isovalue_queue, field_at_point(beat)};
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Output side: random stall pattern, checking of each accepted beat.
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            // Alternate windows of heavy stalling and none at all.
            if (stall_phase[8])
                i_out_stall <= ($urandom_range(0, 3) == 0);
            else
                i_out_stall <= 1'b0;
            if (o_out_valid && !i_out_stall) begin
                if (isovalue_queue.size() == 0) begin
                    report_mismatch("unexpected result", o_out, 0);
                end else begin
                    mfe_pkg::t_out want;
                    want = isovalue_queue.pop_front();
                    if (o_out.isovalue !== want.isovalue)
                        report_mismatch("isovalue", o_out.isovalue, want.isovalue);
                    if (o_out.saturated !== want.saturated)
                        report_mismatch("saturated", o_out.saturated, want.saturated);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Presents one beat and holds it until it is accepted; the sender also
    // takes random gaps between bursts. Valid stays high after the beat so
    // that a burst runs back to back; a gap or a drain drops it.
    int burst_left;
    task automatic send_beat(input mfe_pkg::t_in beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_beat(beat);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == mfe_pkg::CfgResolution)
            shadow_resolution = value;
        else if (idx == mfe_pkg::CfgBallCount)
            shadow_count = value[4:0];
        @(posedge i_clk);
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (isovalue_queue.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic mfe_pkg::t_in load_beat(input int slot, input int cx, input int cy,
                                               input int cz, input int rad);
        mfe_pkg::t_in b;
        b = InBits'({$urandom(), $urandom(), $urandom(), $urandom()});
        b.mode        = 1'b0;
        b.ball_slot   = slot[3:0];
        b.center_x    = cx[23:0];
        b.center_y    = cy[23:0];
        b.center_z    = cz[23:0];
        b.ball_radius = rad[15:0];
        return b;
    endfunction

    function automatic mfe_pkg::t_in eval_beat(input int ix, input int iy, input int iz);
        mfe_pkg::t_in b;
        b = InBits'({$urandom(), $urandom(), $urandom(), $urandom()});
        b.mode    = 1'b1;
        b.index_x = ix[7:0];
        b.index_y = iy[7:0];
        b.index_z = iz[7:0];
        return b;
    endfunction

    function automatic mfe_pkg::t_in random_load();
        mfe_pkg::t_in b;
        // Mostly centres near the grid, now and then anywhere in range.
        if ($urandom_range(0, 3) == 0)
            b = load_beat($urandom_range(0, 15), $urandom(), $urandom(), $urandom(), $urandom());
        else
            b = load_beat($urandom_range(0, 15), $signed($urandom_range(0, 400000)) - 200000,
                          $signed($urandom_range(0, 400000)) - 200000,
                          $signed($urandom_range(0, 400000)) - 200000, $urandom());
        return b;
    endfunction

    function automatic mfe_pkg::t_in random_eval();
        mfe_pkg::t_in b;
        if ($urandom_range(0, 2) == 0)
            b = eval_beat($urandom(), $urandom(), $urandom());
        else
            b = eval_beat($signed($urandom_range(0, 16)) - 8, $signed($urandom_range(0, 16)) - 8,
                          $signed($urandom_range(0, 16)) - 8);
        return b;
    endfunction

    task automatic add_row(input mfe_pkg::t_in beat, input bit has_known,
                           input mfe_pkg::t_out known);
        t_row r;
        r.beat      = beat;
        r.has_known = has_known;
        r.known     = known;
        directed_rows = {directed_rows, r};
    endtask

    initial begin
        mfe_pkg::t_out none;
        mfe_pkg::t_out zero_result;
        mfe_pkg::t_out sat_result;
        int            settings_left;
        none        = '0;
        zero_result = '0;
        sat_result  = {32'hFFFF_FFFF, 1'b1};

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = mfe_pkg::CfgResolution;
        i_cfg_data     = '0;
        mismatch_count = 0;
        burst_left     = 0;
        shadow_resolution = 16'd1638;
        shadow_count      = 5'd0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With no active balls straight after reset the field is zero.
        add_row(eval_beat(127, -128, 0), 1'b1, zero_result);
        // Fill every slot, the extremes of each field among them.
        add_row(load_beat(0, 0, 0, 0, 65535), 1'b0, none);
        add_row(load_beat(1, 8388607, 8388607, 8388607, 0), 1'b0, none);
        add_row(load_beat(2, -8388608, -8388608, -8388608, 65535), 1'b0, none);
        add_row(load_beat(3, 65536, -65536, 1638, 1), 1'b0, none);
        for (int s = 4; s < mfe_pkg::MaxBalls; s++)
            add_row(load_beat(s, s * 9000 - 60000, 30000 - s * 7000, s * 1234, s * 4000), 1'b0,
                    none);
        foreach (directed_rows[i]) begin
            t_row r;
            r = directed_rows[i];
            send_beat(r.beat);
            if (r.has_known && isovalue_queue[$] !== r.known)
                report_mismatch("directed row", isovalue_queue[$], r.known);
        end
        directed_rows.delete();
        wait_drained();

        // One ball at the origin: a point on its centre clips at full scale.
        write_register(mfe_pkg::CfgBallCount, 16'd1);
        add_row(eval_beat(0, 0, 0), 1'b1, sat_result);
        add_row(eval_beat(1, 0, 0), 1'b0, none);
        add_row(eval_beat(-128, -128, -128), 1'b0, none);
        add_row(eval_beat(127, 127, 127), 1'b0, none);
        foreach (directed_rows[i]) begin
            t_row r;
            r = directed_rows[i];
            send_beat(r.beat);
            if (r.has_known && isovalue_queue[$] !== r.known)
                report_mismatch("directed row", isovalue_queue[$], r.known);
        end
        directed_rows.delete();
        wait_drained();

        // A count beyond the largest, then the largest count, and extreme resolutions.
        write_register(mfe_pkg::CfgBallCount, 16'd31);
        write_register(mfe_pkg::CfgResolution, 16'd0);
        send_beat(eval_beat(5, -5, 7));
        wait_drained();
        write_register(mfe_pkg::CfgResolution, 16'hFFFF);
        send_beat(eval_beat(-128, 127, -1));
        send_beat(eval_beat(1, 1, 1));
        wait_drained();
        write_register(mfe_pkg::CfgBallCount, 16'd16);
        write_register(mfe_pkg::CfgResolution, 16'd1);
        send_beat(eval_beat(0, 0, 0));
        wait_drained();

        // Random phases: a register setting, then a mix of loads and evaluations.
        settings_left = RandomItems;
        while (settings_left > 0) begin
            int phase_len;
            case ($urandom_range(0, 4))
                0: write_register(mfe_pkg::CfgResolution, 16'd0);
                1: write_register(mfe_pkg::CfgResolution, 16'hFFFF);
                default: write_register(mfe_pkg::CfgResolution,
                                        16'($urandom_range(200, 20000)));
            endcase
            // Small counts keep most evaluations short.
            if ($urandom_range(0, 5) == 0)
                write_register(mfe_pkg::CfgBallCount, 16'($urandom_range(0, 31)));
            else
                write_register(mfe_pkg::CfgBallCount, 16'($urandom_range(0, 4)));
            phase_len = $urandom_range(40, 120);
            for (int k = 0; k < phase_len && settings_left > 0; k++) begin
                if ($urandom_range(0, 2) == 0)
                    send_beat(random_load());
                else
                    send_beat(random_eval());
                settings_left--;
            end
            wait_drained();
        end

        wait_drained();
        if (mismatch_count == 0 && isovalue_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
